// ===== hdl/tile_mean_hole_fill_assert.svh =====
// ----------------------------------------------------------------------------
// tile_mean_hole_fill assertion macros
// concurrent checks on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef TILE_MEAN_HOLE_FILL_ASSERT_SVH
`define TILE_MEAN_HOLE_FILL_ASSERT_SVH
`ifndef SYNTHESIS
`define TMHF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tile_mean_hole_fill assertion failed");
`define TMHF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tile_mean_hole_fill implication failed");
`else
`define TMHF_ASSERT(lbl, prop)
`define TMHF_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== hdl/tmhf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhf_pkg
// shared constants, types and state codes of the tile mean hole filler
// ----------------------------------------------------------------------------
package tmhf_pkg;

    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int MAX_TILE  = 16;
    localparam int FILL_BIAS = 130;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int PIX_W  = 24;
    localparam int DIM_W  = 9;
    localparam int SIDE_W = 5;
    localparam int OFF_W  = $clog2(MAX_TILE);
    localparam int POS_W  = 10;
    localparam int SUM_W  = 17;
    localparam int CNT_W  = 9;
    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_PAINT = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] REG_TILE_SIZE = 2'd0;
    localparam logic [1:0] REG_ROWS      = 2'd1;
    localparam logic [1:0] REG_COLS      = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_TILE,
        S_GATHER,
        S_GDRAIN,
        S_DIV_START,
        S_DIV_WAIT,
        S_FILL,
        S_FDRAIN,
        S_DONE
    } t_state;

endpackage

// ===== hdl/tmhf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tmhf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tmhf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tmhf_div import tmhf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [SUM_W-1:0] o_quotient
);

    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_dsr, n_dsr;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic [CNT_W:0]    trial;
    logic              ge;

    always_comb begin
        trial  = {r_rem, r_quo[SUM_W-1]};
        ge     = (trial >= {1'b0, r_dsr});
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? CNT_W'(trial - {1'b0, r_dsr}) : trial[CNT_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], ge};
            n_cnt = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/tile_mean_hole_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_mean_hole_fill
// frame store with a tile-mean hole filling pass over possibly overlapping tiles
// ----------------------------------------------------------------------------
// channel | signals                               | direction
// in      | i_in_valid / o_in_stall, i_mode ...   | command transfer in
// out     | o_out_valid / i_out_stall, o_out_ch*  | read or paint result out
// cfg     | psel penable pwrite paddr pwdata ...  | apb register access
//
// a write goes to the frame ram when taken; a read passes the ram read register
// a paint pass reads each tile twice, to gather and then to fill; the single
// ram read port and the serial dividers set how long each tile takes
// reset is synchronous and active low; the frame ram is not cleared
// no command is taken while a read or a pass runs or while a result is stalled
// ----------------------------------------------------------------------------
`include "tile_mean_hole_fill_assert.svh"

module tile_mean_hole_fill import tmhf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_pix_row,
    input  logic [7:0]  i_pix_col,
    input  logic [7:0]  i_in_ch0,
    input  logic [7:0]  i_in_ch1,
    input  logic [7:0]  i_in_ch2,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_ch0,
    output logic [7:0]  o_out_ch1,
    output logic [7:0]  o_out_ch2,
    output logic        o_paint_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state r_state, n_state;

    logic [SIDE_W-1:0] r_tile_size;
    logic [DIM_W-1:0]  r_rows, r_cols;

    logic [DIM_W-1:0]  r_org_row, n_org_row, r_org_col, n_org_col;
    logic [OFF_W-1:0]  r_dr, n_dr, r_dc, n_dc;
    logic [SUM_W-1:0]  r_sum [3];
    logic [SUM_W-1:0]  n_sum [3];
    logic [CNT_W-1:0]  r_cnt [3];
    logic [CNT_W-1:0]  n_cnt [3];
    logic [PIX_W-1:0]  r_mean, n_mean;
    logic              r_rd_v, n_rd_v;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;

    logic              r_out_v, n_out_v;
    logic [PIX_W-1:0]  r_out_pix, n_out_pix;
    logic              r_out_done, n_out_done;

    logic [SIDE_W-1:0] side;
    logic [OFF_W-1:0]  half;
    logic [SIDE_W-1:0] adv;
    logic [DIM_W-1:0]  rows, cols;
    logic [POS_W-1:0]  pix_r, pix_c;
    logic              in_frame, last_pix, row_ok, col_ok;
    logic              accept, out_free, cfg_wr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;
    logic              fill_we;

    logic              div_start;
    logic [2:0]        div_busy;
    logic [SUM_W-1:0]  div_quo [3];

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_size <= SIDE_W'(10);
            r_rows      <= DIM_W'(256);
            r_cols      <= DIM_W'(256);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TILE_SIZE: r_tile_size <= pwdata[SIDE_W-1:0];
                REG_ROWS:      r_rows      <= pwdata[DIM_W-1:0];
                REG_COLS:      r_cols      <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TILE_SIZE: prdata = {{(32-SIDE_W){1'b0}}, r_tile_size};
            REG_ROWS:      prdata = {{(32-DIM_W){1'b0}}, r_rows};
            REG_COLS:      prdata = {{(32-DIM_W){1'b0}}, r_cols};
            default:       prdata = '0;
        endcase
    end

    // clamped geometry
    always_comb begin
        side = (r_tile_size > SIDE_W'(MAX_TILE)) ? SIDE_W'(MAX_TILE) : r_tile_size;
        half = side[SIDE_W-1:1];
        adv  = side - SIDE_W'(half) + SIDE_W'(1);
        rows = (r_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_rows;
        cols = (r_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_cols;
        pix_r    = POS_W'(r_org_row) + POS_W'(r_dr);
        pix_c    = POS_W'(r_org_col) + POS_W'(r_dc);
        in_frame = (pix_r < POS_W'(rows)) && (pix_c < POS_W'(cols));
        last_pix = (SIDE_W'(r_dr) == side - SIDE_W'(1))
                && (SIDE_W'(r_dc) == side - SIDE_W'(1));
        row_ok   = (POS_W'(r_org_row) + POS_W'(half)) <= POS_W'(rows);
        col_ok   = (POS_W'(r_org_col) + POS_W'(half)) < POS_W'(cols);
    end

    assign out_free   = !r_out_v || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_mode == MODE_READ) begin
                    n_state = S_READ;
                end else if (accept && i_mode == MODE_PAINT) begin
                    n_state = (side == '0) ? S_DONE : S_TILE;
                end
            end
            S_READ:      n_state = S_IDLE;
            S_TILE: begin
                if (!row_ok) begin
                    n_state = S_DONE;
                end else if (col_ok) begin
                    n_state = S_GATHER;
                end
            end
            S_GATHER:    n_state = last_pix ? S_GDRAIN : S_GATHER;
            S_GDRAIN:    n_state = S_DIV_START;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT:  n_state = div_busy[0] ? S_DIV_WAIT : S_FILL;
            S_FILL:      n_state = last_pix ? S_FDRAIN : S_FILL;
            S_FDRAIN:    n_state = S_TILE;
            S_DONE:      n_state = out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        n_org_row  = r_org_row;
        n_org_col  = r_org_col;
        n_dr       = r_dr;
        n_dc       = r_dc;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_mean     = r_mean;
        n_rd_v     = 1'b0;
        n_rd_addr  = {pix_r[ROW_W-1:0], pix_c[COL_W-1:0]};
        n_out_v    = r_out_v && i_out_stall;
        n_out_pix  = r_out_pix;
        n_out_done = r_out_done;
        ram_raddr  = {pix_r[ROW_W-1:0], pix_c[COL_W-1:0]};
        div_start  = 1'b0;

        // sums pick up the pixel read in the previous gather cycle
        if (r_rd_v && (r_state == S_GATHER || r_state == S_GDRAIN)) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (ram_rdata[8*ch +: 8] != 8'd0) begin
                    n_sum[ch] = r_sum[ch] + SUM_W'(ram_rdata[8*ch +: 8]);
                    n_cnt[ch] = r_cnt[ch] + CNT_W'(1);
                end
            end
        end

        case (r_state)
            S_IDLE: begin
                ram_raddr = {i_pix_row[ROW_W-1:0], i_pix_col[COL_W-1:0]};
                n_org_row = '0;
                n_org_col = '0;
            end
            S_READ: begin
                n_out_v    = 1'b1;
                n_out_pix  = ram_rdata;
                n_out_done = 1'b0;
            end
            S_TILE: begin
                n_dr = '0;
                n_dc = '0;
                for (int ch = 0; ch < 3; ch++) begin
                    n_sum[ch] = SUM_W'(FILL_BIAS);
                    n_cnt[ch] = CNT_W'(1);
                end
                if (row_ok && !col_ok) begin
                    n_org_row = r_org_row + DIM_W'(adv);
                    n_org_col = '0;
                end
            end
            S_GATHER, S_FILL: begin
                n_rd_v = in_frame;
                if (SIDE_W'(r_dc) == side - SIDE_W'(1)) begin
                    n_dc = '0;
                    n_dr = r_dr + OFF_W'(1);
                end else begin
                    n_dc = r_dc + OFF_W'(1);
                end
            end
            S_DIV_START: div_start = 1'b1;
            S_DIV_WAIT: begin
                n_mean = {div_quo[2][7:0], div_quo[1][7:0], div_quo[0][7:0]};
                n_dr   = '0;
                n_dc   = '0;
            end
            S_FDRAIN: n_org_col = r_org_col + DIM_W'(adv);
            S_DONE: begin
                n_org_row = '0;
                n_org_col = '0;
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_pix  = '0;
                    n_out_done = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // hole write lands in the cycle after its read, at the address carried along
    assign fill_we   = r_rd_v && (r_state == S_FILL || r_state == S_FDRAIN)
                    && (ram_rdata[7:0] == 8'd0);
    assign ram_we    = fill_we || (accept && i_mode == MODE_WRITE);
    assign ram_waddr = fill_we ? r_rd_addr
                     : {i_pix_row[ROW_W-1:0], i_pix_col[COL_W-1:0]};
    assign ram_wdata = fill_we ? r_mean : {i_in_ch2, i_in_ch1, i_in_ch0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_org_row <= '0;
            r_org_col <= '0;
            for (int ch = 0; ch < 3; ch++) begin
                r_sum[ch] <= '0;
                r_cnt[ch] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_rd_v    <= n_rd_v;
            r_out_v   <= n_out_v;
            r_org_row <= n_org_row;
            r_org_col <= n_org_col;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
        end
        r_dr       <= n_dr;
        r_dc       <= n_dc;
        r_mean     <= n_mean;
        r_rd_addr  <= n_rd_addr;
        r_out_pix  <= n_out_pix;
        r_out_done <= n_out_done;
    end

    tmhf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        tmhf_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (r_sum[g]),
            .i_divisor  (r_cnt[g]),
            .o_busy     (div_busy[g]),
            .o_quotient (div_quo[g])
        );
    end

    assign o_out_valid  = r_out_v;
    assign o_out_ch0    = r_out_pix[7:0];
    assign o_out_ch1    = r_out_pix[15:8];
    assign o_out_ch2    = r_out_pix[23:16];
    assign o_paint_done = r_out_done;

    `TMHF_ASSERT_IMPL(a_fill_only_holes, fill_we, ram_rdata[7:0] == 8'd0 && !accept)
    `TMHF_ASSERT_IMPL(a_done_zero, o_out_valid && o_paint_done, r_out_pix == '0)
    `TMHF_ASSERT_IMPL(a_div_idle_in_fill, r_state == S_FILL, div_busy == 3'b000)
    `TMHF_ASSERT(a_read_result, (r_state == S_READ) |=> (o_out_valid && !o_paint_done))

endmodule

// ===== bench/tb_tile_mean_hole_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_mean_hole_fill
// self-checking bench: pixel writes, reads and paint passes under random
// idling on both channels, predicted by a frame model kept in a scoreboard
// ----------------------------------------------------------------------------
module tb_tile_mean_hole_fill;
    import tmhf_pkg::*;

    localparam logic [1:0] MODE_NONE  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic       done;
    } t_pix_result;

    class fill_scoreboard;
        logic [23:0]  frame [0:DEPTH-1];
        bit           written [0:DEPTH-1];
        int           side_cfg = 10;
        int           rows_cfg = 256;
        int           cols_cfg = 256;
        t_pix_result  pending [$];
        int           errors = 0;

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_TILE_SIZE: side_cfg = val[4:0];
                REG_ROWS:      rows_cfg = val[8:0];
                REG_COLS:      cols_cfg = val[8:0];
                default: ;
            endcase
        endfunction

        function void fill_tile(int org_r, int org_c, int s, int nr, int nc);
            int sum [3];
            int cnt [3];
            logic [7:0] avg [3];
            logic [23:0] p;
            int r, c, k;
            for (k = 0; k < 3; k++) begin
                sum[k] = FILL_BIAS;
                cnt[k] = 1;
            end
            for (r = org_r; r < org_r + s; r++)
                for (c = org_c; c < org_c + s; c++) begin
                    if (r >= nr || c >= nc) continue;
                    p = frame[r * MAX_COLS + c];
                    for (k = 0; k < 3; k++)
                        if (p[8*k +: 8] != 0) begin
                            sum[k] += p[8*k +: 8];
                            cnt[k]++;
                        end
                end
            for (k = 0; k < 3; k++) avg[k] = 8'((sum[k] / cnt[k]) & 255);
            for (r = org_r; r < org_r + s; r++)
                for (c = org_c; c < org_c + s; c++) begin
                    if (r >= nr || c >= nc) continue;
                    if (frame[r * MAX_COLS + c][7:0] == 0)
                        frame[r * MAX_COLS + c] = {avg[2], avg[1], avg[0]};
                end
        endfunction

        function void paint_frame();
            int s, nr, nc, half, adv, tr, tc;
            s  = (side_cfg > MAX_TILE) ? MAX_TILE : side_cfg;
            nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
            nc = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
            if (s == 0) return;
            half = s / 2;
            adv  = s - half + 1;
            for (tr = 0; tr < nr - half + 1; tr += adv)
                for (tc = 0; tc < nc - half; tc += adv)
                    fill_tile(tr, tc, s, nr, nc);
        endfunction

        function void note_input(logic [1:0] mode, logic [7:0] row, logic [7:0] col,
                                 logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            t_pix_result res;
            int addr;
            addr = row * MAX_COLS + col;
            case (mode)
                MODE_WRITE: begin
                    frame[addr]   = {c2, c1, c0};
                    written[addr] = 1;
                end
                MODE_PAINT: begin
                    paint_frame();
                    res = '{8'd0, 8'd0, 8'd0, 1'b1};
                    pending.push_back(res);
                end
                MODE_READ: begin
                    res = '{frame[addr][7:0], frame[addr][15:8], frame[addr][23:16], 1'b0};
                    pending.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                   logic done);
            t_pix_result exp_res;
            if (pending.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            exp_res = pending.pop_front();
            if (c0 !== exp_res.ch0 || c1 !== exp_res.ch1 || c2 !== exp_res.ch2
                    || done !== exp_res.done)
                report($sformatf("got %h %h %h done %b, want %h %h %h done %b",
                    c0, c1, c2, done, exp_res.ch0, exp_res.ch1, exp_res.ch2,
                    exp_res.done));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [1:0]  i_mode = MODE_WRITE;
    logic [7:0]  i_pix_row = 0;
    logic [7:0]  i_pix_col = 0;
    logic [7:0]  i_in_ch0 = 0;
    logic [7:0]  i_in_ch1 = 0;
    logic [7:0]  i_in_ch2 = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [7:0]  o_out_ch0;
    logic [7:0]  o_out_ch1;
    logic [7:0]  o_out_ch2;
    logic        o_paint_done;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    fill_scoreboard sb = new();
    int send_idle = 31;
    int recv_idle = 55;
    int results_seen = 0;
    int fr_rows = 256;
    int fr_cols = 256;

    tile_mean_hole_fill dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_ch0, o_out_ch1, o_out_ch2, o_paint_done);
            results_seen++;
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the block
    initial begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall = 1;
                hold--;
            end else if (!held && results_seen >= 30) begin
                held = 1;
                hold = 300;
                i_out_stall = 1;
            end else begin
                i_out_stall = ($urandom_range(99) < recv_idle);
            end
        end
    end

    task automatic send(logic [1:0] mode, logic [7:0] row, logic [7:0] col,
                        logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid = 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid = 1;
        i_mode     = mode;
        i_pix_row  = row;
        i_pix_col  = col;
        i_in_ch0   = c0;
        i_in_ch1   = c1;
        i_in_ch2   = c2;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(mode, row, col, c0, c1, c2);
        @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        i_in_valid = 0;
        psel    = 1;
        penable = 0;
        pwrite  = 1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 0;
        penable = 0;
        pwrite  = 0;
    endtask

    task automatic wait_quiet();
        i_in_valid = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [7:0] hole_value();
        return ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom);
    endfunction

    task automatic random_item(bit paint_ok);
        int pick, r, c, tries;
        pick = $urandom_range(99);
        if (pick < 45) begin
            if (fr_rows > 0 && fr_cols > 0 && $urandom_range(4) != 0) begin
                r = $urandom_range(fr_rows - 1);
                c = $urandom_range(fr_cols - 1);
            end else begin
                r = $urandom_range(255);
                c = $urandom_range(255);
            end
            send(MODE_WRITE, 8'(r), 8'(c), hole_value(), hole_value(), hole_value());
        end else if (pick < 85) begin
            if (fr_rows > 0 && fr_cols > 0 && $urandom_range(3) != 0) begin
                r = $urandom_range(fr_rows - 1);
                c = $urandom_range(fr_cols - 1);
            end else begin
                r = $urandom_range(255);
                c = $urandom_range(255);
            end
            // reads stay on pixels that hold a value
            tries = 0;
            while (!sb.written[r * MAX_COLS + c] && tries < 4) begin
                r = $urandom_range(255);
                c = $urandom_range(255);
                tries++;
            end
            if (!sb.written[r * MAX_COLS + c]) begin
                r = 0;
                c = 0;
            end
            send(MODE_READ, 8'(r), 8'(c), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 93 && paint_ok) begin
            send(MODE_PAINT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
        end else begin
            send(MODE_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
        end
    endtask

    task automatic run_phase(int side, int rows, int cols, int count);
        int r, c;
        wait_quiet();
        apb_write(REG_TILE_SIZE, side);
        apb_write(REG_ROWS, rows);
        apb_write(REG_COLS, cols);
        apb_write(REG_UNUSED, $urandom);
        fr_rows = (rows > MAX_ROWS) ? MAX_ROWS : rows;
        fr_cols = (cols > MAX_COLS) ? MAX_COLS : cols;
        // every frame pixel holds a value before any pass can touch it
        for (r = 0; r < fr_rows; r++)
            for (c = 0; c < fr_cols; c++)
                if (!sb.written[r * MAX_COLS + c])
                    send(MODE_WRITE, 8'(r), 8'(c), hole_value(), hole_value(),
                         hole_value());
        send(MODE_PAINT, 0, 0, 0, 0, 0);
        repeat (count) random_item(1);
        send(MODE_PAINT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // reset sizes: full memory, so no pass here, only written reads
        send(MODE_WRITE, 0, 0, 8'h00, 8'h00, 8'h00);
        send(MODE_WRITE, 255, 255, 8'hff, 8'hff, 8'hff);
        send(MODE_WRITE, 170, 85, 8'haa, 8'h55, 8'haa);
        send(MODE_WRITE, 85, 170, 8'h55, 8'haa, 8'h55);
        send(MODE_READ, 0, 0, 8'hff, 8'hff, 8'hff);
        send(MODE_READ, 255, 255, 8'h00, 8'h00, 8'h00);
        send(MODE_READ, 170, 85, 8'h00, 8'h00, 8'h00);
        send(MODE_READ, 85, 170, 8'h00, 8'h00, 8'h00);
        send(MODE_NONE, 255, 255, 8'hff, 8'hff, 8'hff);
        send(MODE_WRITE, 255, 0, 8'h01, 8'h80, 8'h7f);
        send(MODE_READ, 255, 0, 8'h00, 8'h00, 8'h00);
        repeat (10) random_item(0);

        run_phase(4, 12, 12, 20);
        run_phase(1, 8, 12, 15);
        run_phase(16, 13, 12, 15);
        run_phase(0, 6, 6, 12);       // zero tile
        run_phase(20, 10, 9, 12);     // oversize tile
        send_idle = 55;
        recv_idle = 31;
        run_phase(3, 0, 5, 10);       // no rows
        run_phase(5, 7, 0, 10);       // no columns
        run_phase(2, 300, 1, 15);     // rows clamp to memory
        run_phase(7, 1, 256, 15);
        send_idle = 0;
        recv_idle = 0;
        run_phase(31, 1, 400, 15);    // columns and tile clamp
        run_phase(6, 5, 13, 20);
        run_phase(9, 11, 3, 20);

        wait_quiet();
        if (sb.pending.size() != 0)
            sb.report("results still expected at the end");
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(60_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tmhf_pkg.sv
hdl/tmhf_ram.sv
hdl/tmhf_div.sv
hdl/tile_mean_hole_fill.sv
bench/tb_tile_mean_hole_fill.sv
